FILE: rtl/core/srv_weighted_priority_order_top_defines.svh
`ifndef SRV_WEIGHTED_PRIORITY_ORDER_TOP_DEFINES_SVH
`define SRV_WEIGHTED_PRIORITY_ORDER_TOP_DEFINES_SVH

// Check that prop holds at every clock edge outside reset.
`define SRV_WPO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("srv_wpo assertion failed");

// Check that cond never holds outside reset.
`define SRV_WPO_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("srv_wpo forbidden condition seen");

`endif

FILE: rtl/core/srv_wpo_pkg.sv
`default_nettype none

package srv_wpo_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W       = 16 + CNT_W;
  localparam int SLOT_W      = 4;
  localparam int REC_W       = 32;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_DRAW  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIN,
    S_SUM,
    S_TARGET,
    S_PICK,
    S_FINISH,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_SUM_INIT,
    CMD_TARGET,
    CMD_FINISH
  } cmd_op_e;

  typedef enum logic [1:0] {
    PH_MIN,
    PH_SUM,
    PH_PICK
  } phase_e;

  typedef struct packed {
    cmd_op_e op;
    logic    scan_en;
    phase_e  phase;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic any_pending;
    logic total_zero;
  } sts_t;

  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [SLOT_W+IDX_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/srv_weighted_priority_order_top.sv
// Weighted priority order of SRV records. A request is taken when start is high and busy is
// low; its result appears on the result ports for exactly one cycle with done_o high, and
// the receiver cannot stall it, so it must take the result in that cycle. Clear, load, an
// unused action code and a draw from an empty table go from the idle state straight to the
// done state. A draw with records pending makes three sequential passes over
// the record store through its single registered read port (lowest priority, weight total,
// running-sum pick), a target multiply and a finish step; when every eligible weight is zero
// the pick pass is skipped.
`default_nettype none

module srv_weighted_priority_order_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     action_i,
  input  wire logic [15:0]                    rec_priority_i,
  input  wire logic [15:0]                    rec_weight_i,
  input  wire logic [15:0]                    random_fraction_i,
  output logic                                done_o,
  output logic      [1:0]                     status_o,
  output logic      [srv_wpo_pkg::SLOT_W-1:0] slot_index_o,
  output logic      [15:0]                    out_priority_o,
  output logic      [15:0]                    out_weight_o,
  output logic                                final_pick_o
);

  srv_wpo_pkg::cmd_t cmd;
  srv_wpo_pkg::sts_t sts;

  srv_wpo_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  srv_wpo_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_i          (action_i),
    .rec_priority_i    (rec_priority_i),
    .rec_weight_i      (rec_weight_i),
    .random_fraction_i (random_fraction_i),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .out_priority_o    (out_priority_o),
    .out_weight_o      (out_weight_o),
    .final_pick_o      (final_pick_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/srv_wpo_ram.sv
`default_nettype none

module srv_wpo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/srv_wpo_datapath.sv
`default_nettype none

`include "srv_weighted_priority_order_top_defines.svh"

module srv_wpo_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire srv_wpo_pkg::cmd_t                cmd_i,
  output srv_wpo_pkg::sts_t                     sts_o,
  input  wire logic [1:0]                       action_i,
  input  wire logic [15:0]                      rec_priority_i,
  input  wire logic [15:0]                      rec_weight_i,
  input  wire logic [15:0]                      random_fraction_i,
  output logic      [1:0]                       status_o,
  output logic      [srv_wpo_pkg::SLOT_W-1:0]   slot_index_o,
  output logic      [15:0]                      out_priority_o,
  output logic      [15:0]                      out_weight_o,
  output logic                                  final_pick_o
);

  localparam int N  = srv_wpo_pkg::MAX_RECORDS;
  localparam int IW = srv_wpo_pkg::IDX_W;
  localparam int CW = srv_wpo_pkg::CNT_W;
  localparam int SW = srv_wpo_pkg::SUM_W;
  localparam int TW = srv_wpo_pkg::SLOT_W;

  logic [N-1:0]  mask_q, mask_d;
  logic [CW-1:0] loaded_q, loaded_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          min_vld_q, min_vld_d;
  logic          hit_q, hit_d;

  logic [15:0]   rf_q, rf_d;
  logic [15:0]   min_q, min_d;
  logic [SW-1:0] total_q, total_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [SW-1:0] target_q, target_d;
  logic [IW-1:0] pick_idx_q, pick_idx_d;
  logic [15:0]   pick_prio_q, pick_prio_d;
  logic [15:0]   pick_wt_q, pick_wt_d;

  logic [1:0]    status_q, status_d;
  logic [TW-1:0] slot_q, slot_d;
  logic [15:0]   oprio_q, oprio_d;
  logic [15:0]   owt_q, owt_d;
  logic          final_q, final_d;

  logic                              ram_we;
  logic [IW-1:0]                     ram_waddr;
  logic [srv_wpo_pkg::REC_W-1:0]     ram_wdata;
  logic [IW-1:0]                     ram_raddr;
  logic [srv_wpo_pkg::REC_W-1:0]     ram_rdata;

  logic [15:0]   rd_prio;
  logic [15:0]   rd_wt;
  logic          rd_pend;
  logic          elig;
  logic [SW-1:0] sum_nxt;
  logic [SW+15:0] prod;
  logic [N-1:0]  pick_oh;
  logic [N-1:0]  mask_clr;

  srv_wpo_ram #(
    .WIDTH (srv_wpo_pkg::REC_W),
    .DEPTH (N)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_prio = ram_rdata[31:16];
  assign rd_wt   = ram_rdata[15:0];
  assign rd_pend = mask_q[rd_idx_q];
  assign elig    = rd_vld_q && rd_pend && (rd_prio == min_q);
  assign sum_nxt = sum_q + SW'(rd_wt);
  assign prod    = (SW + 16)'(total_q) * (SW + 16)'(rf_q);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      pick_oh[i] = (pick_idx_q == IW'(i));
    end
  end

  assign mask_clr = mask_q & ~pick_oh;

  always_comb begin
    mask_d      = mask_q;
    loaded_d    = loaded_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    min_vld_d   = min_vld_q;
    hit_d       = hit_q;
    rf_d        = rf_q;
    min_d       = min_q;
    total_d     = total_q;
    sum_d       = sum_q;
    target_d    = target_q;
    pick_idx_d  = pick_idx_q;
    pick_prio_d = pick_prio_q;
    pick_wt_d   = pick_wt_q;
    status_d    = status_q;
    slot_d      = slot_q;
    oprio_d     = oprio_q;
    owt_d       = owt_q;
    final_d     = final_q;
    ram_we      = 1'b0;
    ram_waddr   = loaded_q[IW-1:0];
    ram_wdata   = {rec_priority_i, rec_weight_i};
    ram_raddr   = cnt_q[IW-1:0];

    // issue one read per cycle
    if (cmd_i.scan_en && (cnt_q != srv_wpo_pkg::MAX_CNT)) begin
      rd_vld_d = 1'b1;
      rd_idx_d = cnt_q[IW-1:0];
      cnt_d    = cnt_q + CW'(1);
    end

    if (rd_vld_q) begin
      case (cmd_i.phase)
        srv_wpo_pkg::PH_MIN: begin
          if (rd_pend && (!min_vld_q || (rd_prio < min_q))) begin
            min_d     = rd_prio;
            min_vld_d = 1'b1;
          end
        end
        srv_wpo_pkg::PH_SUM: begin
          if (elig) begin
            total_d     = total_q + SW'(rd_wt);
            pick_idx_d  = rd_idx_q;
            pick_prio_d = rd_prio;
            pick_wt_d   = rd_wt;
          end
        end
        srv_wpo_pkg::PH_PICK: begin
          if (elig && (rd_wt != 16'd0) && !hit_q) begin
            sum_d = sum_nxt;
            if (sum_nxt >= target_q) begin
              hit_d       = 1'b1;
              pick_idx_d  = rd_idx_q;
              pick_prio_d = rd_prio;
              pick_wt_d   = rd_wt;
            end
          end
        end
        default: begin
        end
      endcase
    end

    case (cmd_i.op)
      srv_wpo_pkg::CMD_ACCEPT: begin
        cnt_d     = '0;
        rd_vld_d  = 1'b0;
        min_vld_d = 1'b0;
        rf_d      = random_fraction_i;
        status_d  = srv_wpo_pkg::STS_OK;
        slot_d    = '0;
        oprio_d   = '0;
        owt_d     = '0;
        final_d   = 1'b0;
        case (action_i)
          srv_wpo_pkg::ACT_CLEAR: begin
            mask_d   = '0;
            loaded_d = '0;
          end
          srv_wpo_pkg::ACT_LOAD: begin
            if (loaded_q == srv_wpo_pkg::MAX_CNT) begin
              status_d = srv_wpo_pkg::STS_FULL;
            end else begin
              ram_we                   = 1'b1;
              mask_d[loaded_q[IW-1:0]] = 1'b1;
              slot_d                   = srv_wpo_pkg::slot_field(loaded_q[IW-1:0]);
              loaded_d                 = loaded_q + CW'(1);
            end
          end
          srv_wpo_pkg::ACT_DRAW: begin
            if (mask_q == '0) begin
              status_d = srv_wpo_pkg::STS_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      srv_wpo_pkg::CMD_SUM_INIT: begin
        cnt_d    = '0;
        rd_vld_d = 1'b0;
        total_d  = '0;
      end
      srv_wpo_pkg::CMD_TARGET: begin
        cnt_d    = '0;
        rd_vld_d = 1'b0;
        sum_d    = '0;
        hit_d    = 1'b0;
        target_d = prod[SW+15:16] + SW'(1);
      end
      srv_wpo_pkg::CMD_FINISH: begin
        mask_d   = mask_clr;
        status_d = srv_wpo_pkg::STS_OK;
        slot_d   = srv_wpo_pkg::slot_field(pick_idx_q);
        oprio_d  = pick_prio_q;
        owt_d    = pick_wt_q;
        final_d  = (mask_clr == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      loaded_q  <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      min_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      loaded_q  <= loaded_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      min_vld_q <= min_vld_d;
      hit_q     <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    rf_q        <= rf_d;
    min_q       <= min_d;
    total_q     <= total_d;
    sum_q       <= sum_d;
    target_q    <= target_d;
    pick_idx_q  <= pick_idx_d;
    pick_prio_q <= pick_prio_d;
    pick_wt_q   <= pick_wt_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    oprio_q     <= oprio_d;
    owt_q       <= owt_d;
    final_q     <= final_d;
  end

  assign sts_o.scan_done   = (cnt_q == srv_wpo_pkg::MAX_CNT) && !rd_vld_q;
  assign sts_o.any_pending = |mask_q;
  assign sts_o.total_zero  = (total_q == '0);

  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign out_priority_o = oprio_q;
  assign out_weight_o   = owt_q;
  assign final_pick_o   = final_q;

  `SRV_WPO_ASSERT(a_finish_pick_pending, clk_i, rst_ni,
    (cmd_i.op == srv_wpo_pkg::CMD_FINISH) |-> mask_q[pick_idx_q])
  `SRV_WPO_ASSERT(a_pick_hits_target, clk_i, rst_ni,
    (cmd_i.op == srv_wpo_pkg::CMD_FINISH && !sts_o.total_zero) |-> hit_q)

endmodule

`default_nettype wire

FILE: rtl/core/srv_wpo_ctrl.sv
`default_nettype none

`include "srv_weighted_priority_order_top_defines.svh"

module srv_wpo_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [1:0]        action_i,
  input  wire srv_wpo_pkg::sts_t sts_i,
  output srv_wpo_pkg::cmd_t      cmd_o,
  output logic                   busy,
  output logic                   done_o
);

  srv_wpo_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srv_wpo_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = srv_wpo_pkg::CMD_NONE;
    cmd_o.scan_en = 1'b0;
    cmd_o.phase   = srv_wpo_pkg::PH_MIN;
    busy          = 1'b1;
    done_o        = 1'b0;
    case (state_q)
      srv_wpo_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.op = srv_wpo_pkg::CMD_ACCEPT;
          if ((action_i == srv_wpo_pkg::ACT_DRAW) && sts_i.any_pending) begin
            state_d = srv_wpo_pkg::S_MIN;
          end else begin
            state_d = srv_wpo_pkg::S_DONE;
          end
        end
      end
      srv_wpo_pkg::S_MIN: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.phase   = srv_wpo_pkg::PH_MIN;
        if (sts_i.scan_done) begin
          cmd_o.op = srv_wpo_pkg::CMD_SUM_INIT;
          state_d  = srv_wpo_pkg::S_SUM;
        end
      end
      srv_wpo_pkg::S_SUM: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.phase   = srv_wpo_pkg::PH_SUM;
        if (sts_i.scan_done) begin
          state_d = srv_wpo_pkg::S_TARGET;
        end
      end
      srv_wpo_pkg::S_TARGET: begin
        cmd_o.op = srv_wpo_pkg::CMD_TARGET;
        // all weights zero: keep the fallback pick
        if (sts_i.total_zero) begin
          state_d = srv_wpo_pkg::S_FINISH;
        end else begin
          state_d = srv_wpo_pkg::S_PICK;
        end
      end
      srv_wpo_pkg::S_PICK: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.phase   = srv_wpo_pkg::PH_PICK;
        if (sts_i.scan_done) begin
          state_d = srv_wpo_pkg::S_FINISH;
        end
      end
      srv_wpo_pkg::S_FINISH: begin
        cmd_o.op = srv_wpo_pkg::CMD_FINISH;
        state_d  = srv_wpo_pkg::S_DONE;
      end
      srv_wpo_pkg::S_DONE: begin
        done_o  = 1'b1;
        state_d = srv_wpo_pkg::S_IDLE;
      end
      default: begin
        state_d = srv_wpo_pkg::S_IDLE;
      end
    endcase
  end

  `SRV_WPO_ASSERT(a_draw_enters_scan, clk_i, rst_ni,
    (start && !busy && action_i == srv_wpo_pkg::ACT_DRAW && sts_i.any_pending)
      |=> (state_q == srv_wpo_pkg::S_MIN))
  `SRV_WPO_ASSERT(a_done_then_idle, clk_i, rst_ni, done_o |=> !busy)
  `SRV_WPO_ASSERT_NEVER(a_no_pick_on_zero_total, clk_i, rst_ni,
    (state_q == srv_wpo_pkg::S_PICK) && sts_i.total_zero)

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import srv_wpo_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 600;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    action_e     act;
    logic [15:0] prio;
    logic [15:0] weight;
    logic [15:0] frac;
  } srv_req_t;

  typedef struct {
    status_e     status;
    logic [3:0]  slot;
    logic [15:0] prio;
    logic [15:0] weight;
    logic        fin;
  } srv_reply_t;

  typedef struct {
    srv_req_t   req;
    int         reps;
    bit         typed;
    srv_reply_t reply;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = 2'b00;
  logic [15:0] rec_priority_i = 16'h0000;
  logic [15:0] rec_weight_i = 16'h0000;
  logic [15:0] random_fraction_i = 16'h0000;
  logic        done_o;
  logic [1:0]  status_o;
  logic [SLOT_W-1:0] slot_index_o;
  logic [15:0] out_priority_o;
  logic [15:0] out_weight_o;
  logic        final_pick_o;

  logic [15:0] rec_prio [MAX_RECORDS];
  logic [15:0] rec_weight [MAX_RECORDS];
  bit          rec_live [MAX_RECORDS];
  int          rec_count;

  srv_reply_t  replies_due [$];
  dir_row_t    dir_rows [$];
  srv_reply_t  no_reply;
  int          burst_left;
  int          mismatches;
  int          checked;
  int          cycle_count;
  int          n_loads, n_full, n_draws, n_empty, n_clears;

  srv_weighted_priority_order_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .rec_priority_i    (rec_priority_i),
    .rec_weight_i      (rec_weight_i),
    .random_fraction_i (random_fraction_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .out_priority_o    (out_priority_o),
    .out_weight_o      (out_weight_o),
    .final_pick_o      (final_pick_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic srv_reply_t advance_srv_order(input srv_req_t r);
    srv_reply_t  y;
    bit          found;
    logic [15:0] minp;
    int          zeros [MAX_RECORDS];
    int          rest [MAX_RECORDS];
    int          nz, nr, pick, s, i, k;
    logic [63:0] total, target, sum;
    y.status = STS_OK;
    y.slot = '0;
    y.prio = '0;
    y.weight = '0;
    y.fin = 1'b0;
    found = 1'b0;
    minp = '0;
    nz = 0;
    nr = 0;
    total = '0;
    case (r.act)
      ACT_CLEAR: begin
        for (i = 0; i < MAX_RECORDS; i++) rec_live[i] = 1'b0;
        rec_count = 0;
      end
      ACT_LOAD: begin
        if (rec_count >= MAX_RECORDS) begin
          y.status = STS_FULL;
        end else begin
          rec_prio[rec_count] = r.prio;
          rec_weight[rec_count] = r.weight;
          rec_live[rec_count] = 1'b1;
          y.slot = 4'(rec_count);
          rec_count++;
        end
      end
      ACT_DRAW: begin
        for (i = 0; i < MAX_RECORDS; i++) begin
          if (rec_live[i] && (!found || rec_prio[i] < minp)) begin
            minp = rec_prio[i];
            found = 1'b1;
          end
        end
        if (!found) begin
          y.status = STS_EMPTY;
        end else begin
          for (i = 0; i < MAX_RECORDS; i++) begin
            if (rec_live[i] && rec_prio[i] == minp) begin
              if (rec_weight[i] == 16'd0) begin
                zeros[nz] = i;
                nz++;
              end else begin
                rest[nr] = i;
                nr++;
                total += rec_weight[i];
              end
            end
          end
          pick = (nz > 0) ? zeros[nz-1] : rest[0];
          if (total != 0) begin
            target = 64'd1 + ((total * r.frac) >> 16);
            sum = '0;
            for (k = 0; k < nz + nr; k++) begin
              s = (k < nz) ? zeros[nz-1-k] : rest[k-nz];
              sum += rec_weight[s];
              if (sum >= target) begin
                pick = s;
                break;
              end
            end
          end
          rec_live[pick] = 1'b0;
          y.slot = 4'(pick);
          y.prio = rec_prio[pick];
          y.weight = rec_weight[pick];
          y.fin = 1'b1;
          for (i = 0; i < MAX_RECORDS; i++) begin
            if (rec_live[i]) y.fin = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return y;
  endfunction

  task automatic issue(input srv_req_t r, input bit typed, input srv_reply_t typed_y);
    srv_reply_t y;
    int         gap;
    action_i <= r.act;
    rec_priority_i <= r.prio;
    rec_weight_i <= r.weight;
    random_fraction_i <= r.frac;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    y = advance_srv_order(r);
    replies_due.push_back(typed ? typed_y : y);
    case (r.act)
      ACT_CLEAR: n_clears++;
      ACT_LOAD:  if (y.status == STS_FULL) n_full++; else n_loads++;
      ACT_DRAW:  if (y.status == STS_EMPTY) n_empty++; else n_draws++;
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(1, 70);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic add_row(input action_e act, input logic [15:0] p, input logic [15:0] w,
                         input logic [15:0] f, input int reps, input int typed,
                         input status_e st, input logic [3:0] sl, input logic [15:0] op,
                         input logic [15:0] ow, input int fin);
    dir_row_t row;
    row.req.act = act;
    row.req.prio = p;
    row.req.weight = w;
    row.req.frac = f;
    row.reps = reps;
    row.typed = (typed != 0);
    row.reply.status = st;
    row.reply.slot = sl;
    row.reply.prio = op;
    row.reply.weight = ow;
    row.reply.fin = (fin != 0);
    dir_rows.push_back(row);
  endtask

  function automatic logic [15:0] shaped_value();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin : result_check
    srv_reply_t want;
    if (rst_ni && done_o) begin
      checked++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: status %0d slot %0d prio %h weight %h final %b",
                   status_o, slot_index_o, out_priority_o, out_weight_o, final_pick_o);
      end else begin
        want = replies_due.pop_front();
        if (status_o !== want.status || slot_index_o !== want.slot ||
            out_priority_o !== want.prio || out_weight_o !== want.weight ||
            final_pick_o !== want.fin) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch: exp status %0d slot %0d prio %h weight %h final %b",
                     want.status, want.slot, want.prio, want.weight, want.fin);
            $display("          got status %0d slot %0d prio %h weight %h final %b",
                     status_o, slot_index_o, out_priority_o, out_weight_o, final_pick_o);
          end
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
             replies_due.size());
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    srv_req_t r;
    int       rnd_items, nrec, ndraw, k;
    rec_count = 0;
    foreach (rec_live[i]) rec_live[i] = 1'b0;
    burst_left = 0;
    mismatches = 0;
    checked = 0;
    n_loads = 0;
    n_full = 0;
    n_draws = 0;
    n_empty = 0;
    n_clears = 0;
    no_reply.status = STS_OK;
    no_reply.slot = '0;
    no_reply.prio = '0;
    no_reply.weight = '0;
    no_reply.fin = 1'b0;

    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h0000, 1, 1, STS_EMPTY, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_NOP,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'hFFFF, 16'hFFFF, 16'h0000, 1, 1, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h0000, 16'h0000, 16'h0000, 1, 1, STS_OK, 4'd1, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h0000, 16'h0000, 16'h0000, 1, 1, STS_OK, 4'd2, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h0000, 16'hFFFF, 16'h0000, 1, 1, STS_OK, 4'd3, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h0000, 16'h0001, 16'h0000, 1, 1, STS_OK, 4'd4, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h0005, 16'h000A, 16'h0000, 1, 1, STS_OK, 4'd5, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'hFFFF, 1, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h0000, 1, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h0000, 1, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h8000, 1, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h4000, 1, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h0003, 16'h0007, 16'h0000, 1, 1, STS_OK, 4'd6, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h1234, 1, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h0000, 1, 1, STS_OK, 4'd0, 16'hFFFF, 16'hFFFF, 1);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h0000, 1, 1, STS_EMPTY, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h8000, 16'h1234, 16'h0000, 9, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h0001, 16'h0001, 16'h0000, 1, 1, STS_FULL, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h8000, 9, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'h0000, 1, 1, STS_EMPTY, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1, 1, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_LOAD,  16'h0001, 16'h0002, 16'h0000, 1, 1, STS_OK, 4'd0, 16'h0, 16'h0, 0);
    add_row(ACT_DRAW,  16'h0000, 16'h0000, 16'hFFFF, 1, 0, STS_OK, 4'd0, 16'h0, 16'h0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[j]) begin
      repeat (dir_rows[j].reps) issue(dir_rows[j].req, dir_rows[j].typed, dir_rows[j].reply);
    end

    rnd_items = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        r.act = action_e'($urandom_range(0, 3));
        r.prio = 16'($urandom);
        r.weight = 16'($urandom);
        r.frac = 16'($urandom);
        issue(r, 1'b0, no_reply);
        if (r.act != ACT_NOP) rnd_items++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          r.act = ACT_CLEAR;
          r.prio = 16'($urandom);
          r.weight = 16'($urandom);
          r.frac = 16'($urandom);
          issue(r, 1'b0, no_reply);
          rnd_items++;
        end
        nrec = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 18);
        for (k = 0; k < nrec; k++) begin
          r.act = ACT_LOAD;
          r.prio = shaped_value();
          r.weight = shaped_value();
          r.frac = 16'($urandom);
          issue(r, 1'b0, no_reply);
          rnd_items++;
        end
        ndraw = nrec + $urandom_range(0, 2);
        for (k = 0; k < ndraw; k++) begin
          r.act = ACT_DRAW;
          r.prio = 16'($urandom);
          r.weight = 16'($urandom);
          r.frac = shaped_value();
          issue(r, 1'b0, no_reply);
          rnd_items++;
        end
      end
    end

    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (3 * MAX_RECORDS + 12) @(posedge clk_i);

    $display("covered %0d loads, %0d full-table drops, %0d draws, %0d empty draws, %0d clears",
             n_loads, n_full, n_draws, n_empty, n_clears);
    $display("results checked: %0d, mismatches: %0d", checked, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
